// ===== hw/rtl/jcwf_pkg.sv =====
// shared types, codes and result builders for the jtag command word framer
`default_nettype none

package jcwf_pkg;

    localparam int COUNT_W   = 13;
    localparam int WORD_W    = 16;
    localparam int PAYLOAD_W = 32;
    localparam int HALVES_W  = 10;
    localparam int COUNT_MAX = 8191;

    // input op codes
    localparam logic [1:0] OP_STEP = 2'd0;
    localparam logic [1:0] OP_END  = 2'd1;
    localparam logic [1:0] OP_TDO  = 2'd2;

    typedef enum logic [1:0] {
        KIND_WORD  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_TDO   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [PAYLOAD_W-1:0]   payload;
        logic [COUNT_W-1:0]     count;
        logic                   tend;
        logic                   last;
    } result_t;

    // results caused by one input transaction, n of them (0 to 2)
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } res_pair_t;

    // close event from the step packer to the tdo aligner
    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] samples;
    } close_t;

    function automatic result_t mk_word(input logic [WORD_W-1:0] acc, input logic last);
        result_t r;
        r.kind    = KIND_WORD;
        r.payload = {16'd0, acc};
        r.count   = '0;
        r.tend    = 1'b0;
        r.last    = last;
        return r;
    endfunction

    function automatic result_t mk_close(input logic [COUNT_W-1:0] samples,
                                         input logic [COUNT_W-1:0] steps);
        result_t r;
        r.kind    = KIND_CLOSE;
        r.payload = {19'd0, samples};
        r.count   = steps;
        r.tend    = 1'b0;
        r.last    = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/jcwf_pack.sv =====
// step packer: builds command words and closes transfers
`default_nettype none

module jcwf_pack
    import jcwf_pkg::*;
#(
    parameter int STEP_LIMIT = 8191
)(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire logic [1:0] op,
    input  wire logic       tdi_bit,
    input  wire logic       tms_bit,
    input  wire logic       clock_toggle,
    input  wire logic       sample_enable,
    output res_pair_t       pair,
    output close_t          close_evt
);

    localparam logic [COUNT_W-1:0] LimitW = COUNT_W'(STEP_LIMIT);

    logic [COUNT_W-1:0] step_reg, step_next;
    logic [COUNT_W-1:0] samp_reg, samp_next;
    logic [WORD_W-1:0]  acc_reg, acc_next;

    logic [1:0]         pos;
    logic [WORD_W-1:0]  base;
    logic [3:0]         bits;
    logic [WORD_W-1:0]  acc_add;
    logic [COUNT_W-1:0] step_inc;
    logic [COUNT_W-1:0] samp_inc;
    logic [WORD_W-1:0]  end_word;
    logic [COUNT_W-1:0] end_steps;

    // packing, limit check and end handling
    always_comb
    begin
        pos      = step_reg[1:0];
        base     = (pos == 2'd0) ? '0 : acc_reg;
        bits     = {sample_enable, clock_toggle, tms_bit, tdi_bit};
        for (int g = 0; g < 4; g++)
        begin
            acc_add[g*4 +: 4] = base[g*4 +: 4] | ({3'b000, bits[g]} << pos);
        end
        step_inc  = step_reg + 13'd1;
        samp_inc  = samp_reg + {12'd0, sample_enable};
        // a step count on a word boundary gets an all-zero dummy step first
        end_word  = (pos == 2'd0) ? '0 : acc_reg;
        end_steps = (pos == 2'd0) ? step_inc : step_reg;

        step_next = step_reg;
        samp_next = samp_reg;
        acc_next  = acc_reg;
        pair      = '0;
        close_evt = '0;

        if (fire)
        begin
            unique case (op)
                OP_STEP:
                begin
                    step_next = step_inc;
                    samp_next = samp_inc;
                    acc_next  = acc_add;
                    if (step_inc >= LimitW)
                    begin
                        pair.n            = 2'd2;
                        pair.r0           = mk_word(acc_add, 1'b0);
                        pair.r1           = mk_close(samp_inc, step_inc);
                        close_evt.valid   = 1'b1;
                        close_evt.samples = samp_inc;
                        step_next         = '0;
                        samp_next         = '0;
                        acc_next          = '0;
                    end
                    else if (step_inc[1:0] == 2'd0)
                    begin
                        pair.n  = 2'd1;
                        pair.r0 = mk_word(acc_add, 1'b1);
                    end
                end
                OP_END:
                begin
                    if (step_reg != '0)
                    begin
                        pair.n            = 2'd2;
                        pair.r0           = mk_word(end_word, 1'b0);
                        pair.r1           = mk_close(samp_reg, end_steps);
                        close_evt.valid   = 1'b1;
                        close_evt.samples = samp_reg;
                        step_next         = '0;
                        samp_next         = '0;
                        acc_next          = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // packer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            samp_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            step_reg <= step_next;
            samp_reg <= samp_next;
            acc_reg  <= acc_next;
        end
    end

    // open transfer always stays below the step limit
    a_step_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg < LimitW)
        else $error("step count reached the limit without closing");

    // sampled steps are a subset of all steps
    a_samples_le_steps: assert property (@(posedge clk) disable iff (!rst_n)
        samp_reg <= step_reg)
        else $error("sample count exceeds step count");

    // an end on an open transfer leaves it empty
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && op == OP_END && step_reg != '0) |=> (step_reg == '0))
        else $error("end op did not close the transfer");

endmodule

`default_nettype wire

// ===== hw/rtl/jcwf_tdo.sv =====
// tdo aligner: pairs returned halfwords into aligned words
`default_nettype none

module jcwf_tdo
    import jcwf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire logic [1:0]  op,
    input  wire logic [15:0] tdo_half,
    input  close_t           close_evt,
    output res_pair_t        pair
);

    logic [COUNT_W-1:0]  cs_reg, cs_next;
    logic [HALVES_W-1:0] h_reg, h_next;
    logic [WORD_W-1:0]   hold_reg, hold_next;

    logic [COUNT_W:0]      sum;
    logic [HALVES_W-1:0]   total;
    logic [HALVES_W-1:0]   aligned;
    logic [HALVES_W-1:0]   h_inc;
    logic [1:0]            tail;
    logic [4:0]            shift;
    logic [PAYLOAD_W-1:0]  wide;
    logic [PAYLOAD_W-1:0]  mask;

    // halfword bookkeeping and tail alignment
    always_comb
    begin
        sum     = {1'b0, cs_reg} + 14'd15;
        total   = sum[13:4];
        aligned = {1'b0, cs_reg[12:5], 1'b0};
        h_inc   = h_reg + 10'd1;
        tail    = 2'(total - aligned);
        shift   = (cs_reg[3:0] != 4'd0) ? (5'd16 - {1'b0, cs_reg[3:0]}) : 5'd0;
        wide    = (tail == 2'd2) ? {tdo_half, hold_reg} : {16'd0, tdo_half};
        mask    = (32'd1 << cs_reg[4:0]) - 32'd1;

        cs_next   = cs_reg;
        h_next    = h_reg;
        hold_next = hold_reg;
        pair      = '0;
        pair.r0.kind = KIND_TDO;
        pair.r0.last = 1'b1;

        if (close_evt.valid)
        begin
            cs_next = close_evt.samples;
            h_next  = '0;
        end
        else if (fire && op == OP_TDO && cs_reg != '0 && h_reg < total)
        begin
            h_next = h_inc;
            if (h_reg < aligned)
            begin
                if (!h_reg[0])
                begin
                    hold_next = tdo_half;
                end
                else
                begin
                    pair.n          = 2'd1;
                    pair.r0.payload = {tdo_half, hold_reg};
                    pair.r0.count   = 13'd32;
                    pair.r0.tend    = (h_inc == total);
                end
            end
            else if (tail == 2'd2 && h_reg == aligned)
            begin
                hold_next = tdo_half;
            end
            else
            begin
                pair.n          = 2'd1;
                pair.r0.payload = (wide >> shift) & mask;
                pair.r0.count   = {8'd0, cs_reg[4:0]};
                pair.r0.tend    = 1'b1;
            end
        end
    end

    // aligner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_reg   <= '0;
            h_reg    <= '0;
            hold_reg <= '0;
        end
        else
        begin
            cs_reg   <= cs_next;
            h_reg    <= h_next;
            hold_reg <= hold_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/jcwf_outq.sv =====
// result queue: two input transactions deep, one result out per cycle while out_ready is high
`default_nettype none

module jcwf_outq
    import jcwf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  res_pair_t  push_pair,
    output logic       full,
    output logic       out_valid,
    input  wire logic  out_ready,
    output result_t    cur
);

    res_pair_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       sel_reg, sel_next;
    logic [1:0] cnt_reg, cnt_next;

    res_pair_t  head;
    logic       pop_res;
    logic       entry_done;

    // head selection and pointer updates
    always_comb
    begin
        head       = mem_reg[rd_ptr_reg];
        cur        = sel_reg ? head.r1 : head.r0;
        out_valid  = (cnt_reg != 2'd0);
        full       = (cnt_reg == 2'd2);
        pop_res    = out_valid && out_ready;
        entry_done = sel_reg || (head.n != 2'd2);

        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = (pop_res && entry_done) ? ~rd_ptr_reg : rd_ptr_reg;
        sel_next    = pop_res ? !entry_done : sel_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop_res && entry_done};
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_pair;
        end
    end

    // queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            sel_reg    <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            sel_reg    <= sel_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result queue overflow");

    // second result only selected for entries that hold two
    a_sel_two: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && sel_reg) |-> (head.n == 2'd2))
        else $error("second result selected on single-result entry");

    // the final result of an entry carries last
    a_last_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && entry_done) |-> cur.last)
        else $error("entry finished without last");

endmodule

`default_nettype wire

// ===== hw/rtl/jtag_command_word_framer.sv =====
// top level of the jtag command word framer
//
// Usage: each input transaction (in_valid/in_ready) carries one op: a JTAG
// bit step, an end of sequence, or one returned TDO halfword. Results leave
// on the output channel (out_valid/out_ready) in order, one per cycle
// while out_ready is high. A step transaction yields no result, a full
// command word, or a command word plus a transfer close when the step
// limit is hit; an end yields the partial word and a close; a halfword
// yields at most one aligned TDO word. Throughput: one input transaction
// per cycle while in_ready is high; an input that causes two results
// holds the output until both are taken. The result queue holds results
// of two transactions, so in_ready drops only when both slots are taken,
// which happens only while the receiver stalls or double results pile
// up. Reset clears all counters, the word accumulator and the queue; no
// result is pending after reset. A stalled receiver never loses results:
// the input side simply backs up once the queue is full.
`default_nettype none

module jtag_command_word_framer
    import jcwf_pkg::*;
#(
    parameter int MAX_STEPS = 8191
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic        tdi_bit,
    input  wire logic        tms_bit,
    input  wire logic        clock_toggle,
    input  wire logic        sample_enable,
    input  wire logic [15:0] tdo_half,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [31:0]      payload,
    output logic [12:0]      count,
    output logic             transfer_end,
    output logic             last
);

    localparam int StepLimit = (MAX_STEPS > COUNT_MAX) ? COUNT_MAX : MAX_STEPS;

    logic      fire;
    logic      full;
    res_pair_t pack_pair;
    res_pair_t tdo_pair;
    res_pair_t push_pair;
    close_t    close_evt;
    result_t   cur;

    assign in_ready = !full;
    assign fire     = in_valid && in_ready;

    jcwf_pack #(
        .STEP_LIMIT (StepLimit)
    ) u_pack (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .op            (op),
        .tdi_bit       (tdi_bit),
        .tms_bit       (tms_bit),
        .clock_toggle  (clock_toggle),
        .sample_enable (sample_enable),
        .pair          (pack_pair),
        .close_evt     (close_evt)
    );

    jcwf_tdo u_tdo (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .op        (op),
        .tdo_half  (tdo_half),
        .close_evt (close_evt),
        .pair      (tdo_pair)
    );

    // only one of the two sources produces results for a given op
    assign push_pair = (pack_pair.n != 2'd0) ? pack_pair : tdo_pair;

    jcwf_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_pair.n != 2'd0),
        .push_pair (push_pair),
        .full      (full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cur       (cur)
    );

    // result fields
    assign kind         = cur.kind;
    assign payload      = cur.payload;
    assign count        = cur.count;
    assign transfer_end = cur.tend;
    assign last         = cur.last;

endmodule

`default_nettype wire
